// File: sv/mri_pkg.sv
package mri_pkg;

  localparam int MAX_PARTICLES = 256;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int ADDR_W = $clog2(MAX_PARTICLES);
  localparam int SUM_W = 25;
  localparam int VAL_W = 17;
  localparam int IDX_W = 9;
  localparam int ACT_W = 2;

  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DRAW = 2'd2;

  typedef struct packed {
    logic clear;
    logic load;
    logic start;
    logic step;
    logic deliver;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic srch_done;
    logic out_busy;
  } sts_t;

endpackage

// File: sv/mri_ram.sv
module mri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/mri_ctrl.sv
module mri_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [mri_pkg::ACT_W-1:0] in_action,
  output logic                      in_ready,
  input  mri_pkg::sts_t             sts,
  output mri_pkg::cmd_t             cmd
);
  import mri_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_action)
            ACT_CLEAR: cmd.clear = 1'b1;
            ACT_LOAD: cmd.load = 1'b1;
            ACT_DRAW: begin
              cmd.start = 1'b1;
              state_nxt = sts.empty ? ST_DONE : ST_SEARCH;
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.srch_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.deliver = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ready)
    else $error("item taken while a draw is in progress");
  a_search_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH && sts.srch_done |=> state_r == ST_DONE)
    else $error("search did not hand over to delivery");
  a_empty_skips: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start && sts.empty |=> state_r == ST_DONE)
    else $error("draw on an empty set entered the search");
`endif

endmodule

// File: sv/mri_dp.sv
module mri_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mri_pkg::cmd_t             cmd,
  output mri_pkg::sts_t             sts,
  input  logic [mri_pkg::VAL_W-1:0] in_weight,
  input  logic [mri_pkg::VAL_W-1:0] in_uniform,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mri_pkg::IDX_W-1:0] out_index,
  output logic                      out_not_found
);
  import mri_pkg::*;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTICLES);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] run_sum_r, run_sum_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [VAL_W-1:0] uniform_r;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_index_r;
  logic             out_not_found_r;

  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;
  logic             ram_we;
  logic [SUM_W-1:0] ram_rdata;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] step_lo, step_hi;
  logic             above;

  assign sum_wide = {1'b0, run_sum_r} + (SUM_W + 1)'(in_weight);
  assign sum_sat = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign ram_we = cmd.load && (count_r != CNT_MAX);

  assign above = ram_rdata > SUM_W'(uniform_r);
  assign step_lo = above ? lo_r : mid_r + CNT_W'(1);
  assign step_hi = above ? mid_r : hi_r;

  always_comb begin
    count_nxt = count_r;
    run_sum_nxt = run_sum_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.clear) begin
      count_nxt = '0;
      run_sum_nxt = '0;
    end
    if (ram_we) begin
      count_nxt = count_r + CNT_W'(1);
      run_sum_nxt = sum_sat;
    end
    if (cmd.start) begin
      lo_nxt = '0;
      hi_nxt = count_r;
    end
    if (cmd.step) begin
      lo_nxt = step_lo;
      hi_nxt = step_hi;
    end
  end

  assign mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
  assign mid_nxt = CNT_W'(mid_sum >> 1);

  assign sts.empty = (count_r == '0);
  assign sts.srch_done = (step_lo == step_hi);
  assign sts.out_busy = out_valid_r && !out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.deliver) begin
      out_valid_nxt = 1'b1;
    end
  end

  mri_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_PARTICLES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[ADDR_W-1:0]),
    .wdata(sum_sat),
    .raddr(mid_nxt[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      run_sum_r <= '0;
      lo_r <= '0;
      hi_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      run_sum_r <= run_sum_nxt;
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mid_r <= mid_nxt;
    if (cmd.start) begin
      uniform_r <= in_uniform;
    end
    if (cmd.deliver) begin
      out_index_r <= IDX_W'(lo_r);
      out_not_found_r <= (lo_r == count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_not_found = out_not_found_r;

`ifndef SYNTHESIS
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    lo_r <= hi_r)
    else $error("search bounds crossed");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("loaded count beyond capacity");
  a_sum_rises: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> run_sum_r >= $past(run_sum_r))
    else $error("running sum fell on a load");
`endif

endmodule

// File: sv/multinomial_resample_index.sv
// Channel  Direction  Ports
// in       request    in_valid, in_ready, in_action, in_weight, in_uniform
// out      result     out_valid, out_ready, out_index, out_not_found
//
// Clear and load requests leave the block idle; the next request is taken in the following cycle.
// A draw runs a binary search over the cumulative-sum RAM, which issues one read of that RAM per cycle.
// A draw on an empty set skips the search and goes straight to delivery.
// Reset is synchronous and active low; it empties the weight set and the result register.
// A waiting result holds the block in its last draw cycle only until the result register frees.
module multinomial_resample_index (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mri_pkg::ACT_W-1:0] in_action,
  input  logic [mri_pkg::VAL_W-1:0] in_weight,
  input  logic [mri_pkg::VAL_W-1:0] in_uniform,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mri_pkg::IDX_W-1:0] out_index,
  output logic                      out_not_found
);
  import mri_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mri_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_action),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mri_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_weight    (in_weight),
    .in_uniform   (in_uniform),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_index    (out_index),
    .out_not_found(out_not_found)
  );

endmodule
